>>> rtl/rau_pkg.sv
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies; imported by every module of the block
package rau_pkg;

    localparam int MAG_W = 32;
    localparam int PROD_W = 2 * MAG_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] left_num;
        logic signed [31:0] left_den;
        logic signed [31:0] right_num;
        logic signed [31:0] right_den;
    } t_req;

    typedef struct packed {
        logic signed [63:0] result_num;
        logic [62:0]        result_den;
        logic               status;
    } t_res;

    // classified job handed from front to back
    typedef struct packed {
        t_op              op;
        logic             err;
        logic             ln_neg;
        logic             rn_neg;
        logic [MAG_W-1:0] ln;
        logic [MAG_W-1:0] ld;
        logic [MAG_W-1:0] rn;
        logic [MAG_W-1:0] rd;
    } t_job;

endpackage

>>> rtl/rau_front.sv
// rau_front: takes request transfers, splits operands into sign and magnitude
// and flags zero denominators and division by a zero fraction; depends on rau_pkg
module rau_front #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic          i_valid,
    output logic          o_stall,
    input  rau_pkg::t_req i_req,
    input  logic          i_full,
    output logic          o_push,
    output rau_pkg::t_job o_job
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0] ln_m, ld_m, rn_m, rd_m;
    logic         ln_s, ld_s, rn_s, rd_s;
    t_op          op;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        logic [W-1:0] m;
        m = v[W-1] ? (~v + 1'b1) : v;
        // most negative value negates to itself, which is already its magnitude
        if (v[W-1] && (m == '0)) begin
            m = {1'b1, {(W-1){1'b0}}};
        end
        return m;
    endfunction

    always_comb begin
        op   = t_op'(i_req.req_type);
        ln_s = i_req.left_num[W-1];
        ld_s = i_req.left_den[W-1];
        rn_s = i_req.right_num[W-1];
        rd_s = i_req.right_den[W-1];
        ln_m = mag_of(i_req.left_num[W-1:0]);
        ld_m = mag_of(i_req.left_den[W-1:0]);
        rn_m = mag_of(i_req.right_num[W-1:0]);
        rd_m = mag_of(i_req.right_den[W-1:0]);

        o_job.op     = op;
        o_job.err    = (ld_m == '0) || (rd_m == '0) || ((op == OP_DIV) && (rn_m == '0));
        o_job.ln_neg = ln_s ^ ld_s;
        o_job.rn_neg = rn_s ^ rd_s ^ (op == OP_SUB);
        o_job.ln     = MAG_W'(ln_m);
        o_job.ld     = MAG_W'(ld_m);
        o_job.rn     = MAG_W'(rn_m);
        o_job.rd     = MAG_W'(rd_m);
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

>>> rtl/rau_queue.sv
// rau_queue: two-entry job queue between front and back
// depends on rau_pkg
module rau_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rau_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rau_pkg::t_job o_job
);
    import rau_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> rtl/rau_back.sv
// rau_back: cross-products on one shared multiplier, binary gcd, then two
// bit-serial exact divisions and the result register; depends on rau_pkg
module rau_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    output logic          o_pop,
    input  rau_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_stall,
    output rau_pkg::t_res o_res
);
    import rau_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [1:0]        r_mcnt;
    logic [PROD_W-1:0] r_t1, r_t2, r_nmag, r_dmag;
    logic [PROD_W-1:0] r_ga, r_gb, r_g, r_rem_n, r_rem_d;
    logic [6:0]        r_k;
    logic [5:0]        r_dcnt;
    logic              r_neg, r_err;
    logic              r_out_valid;
    t_res              r_out;

    logic [MAG_W-1:0]  m_a, m_b;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum_mag;
    logic              sum_neg, same;
    logic [PROD_W-1:0] rem_n2, rem_d2;
    logic              ge_n, ge_d;
    logic              out_free;
    logic [PROD_W-1:0] sat_mag;

    always_comb begin
        unique case (r_mcnt)
            2'd0:    begin m_a = r_job.ln; m_b = (r_job.op == OP_MUL) ? r_job.rn : r_job.rd; end
            2'd1:    begin m_a = r_job.ld; m_b = (r_job.op == OP_DIV) ? r_job.rn : r_job.rd; end
            default: begin m_a = r_job.rn; m_b = r_job.ld; end
        endcase
        prod = PROD_W'(m_a) * PROD_W'(m_b);
    end

    // signed-magnitude combine for add and subtract
    always_comb begin
        same = (r_job.ln_neg == r_job.rn_neg);
        if (r_job.op == OP_MUL || r_job.op == OP_DIV) begin
            sum_mag = r_t1;
            sum_neg = r_job.ln_neg ^ r_job.rn_neg;
        end else if (same) begin
            sum_mag = r_t1 + r_t2;
            sum_neg = r_job.ln_neg;
        end else if (r_t1 >= r_t2) begin
            sum_mag = r_t1 - r_t2;
            sum_neg = r_job.ln_neg;
        end else begin
            sum_mag = r_t2 - r_t1;
            sum_neg = r_job.rn_neg;
        end
    end

    // one restoring step for numerator and denominator side by side
    always_comb begin
        rem_n2 = {r_rem_n[PROD_W-2:0], r_nmag[PROD_W-1]};
        rem_d2 = {r_rem_d[PROD_W-2:0], r_dmag[PROD_W-1]};
        ge_n   = (rem_n2 >= r_g);
        ge_d   = (rem_d2 >= r_g);
    end

    always_comb begin
        sat_mag = r_nmag;
        if (r_neg && r_nmag[PROD_W-1] && (r_nmag[PROD_W-2:0] != '0)) begin
            sat_mag = {1'b1, {(PROD_W-1){1'b0}}};
        end else if (!r_neg && r_nmag[PROD_W-1]) begin
            sat_mag = {1'b0, {(PROD_W-1){1'b1}}};
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job  <= i_job;
                        r_mcnt <= 2'd0;
                        r_err  <= i_job.err;
                        r_nmag <= '0;
                        r_dmag <= '0;
                        r_neg  <= 1'b0;
                        r_state <= i_job.err ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    unique case (r_mcnt)
                        2'd0:    r_t1   <= prod;
                        2'd1:    r_dmag <= prod;
                        default: r_t2   <= prod;
                    endcase
                    if ((r_mcnt == 2'd2) ||
                        ((r_mcnt == 2'd1) && (r_job.op == OP_MUL || r_job.op == OP_DIV))) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (sum_mag == '0) begin
                        r_nmag  <= '0;
                        r_dmag  <= PROD_W'(1);
                        r_neg   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_neg   <= sum_neg;
                        r_nmag  <= sum_mag;
                        r_ga    <= sum_mag;
                        r_gb    <= r_dmag;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_ga == '0) begin
                        r_g     <= r_gb << r_k;
                        r_rem_n <= '0;
                        r_rem_d <= '0;
                        r_dcnt  <= '1;
                        r_state <= S_DIV;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_k  <= r_k + 7'd1;
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga >= r_gb) begin
                        r_ga <= (r_ga - r_gb) >> 1;
                    end else begin
                        r_gb <= (r_gb - r_ga) >> 1;
                    end
                end
                S_DIV: begin
                    r_rem_n <= ge_n ? (rem_n2 - r_g) : rem_n2;
                    r_rem_d <= ge_d ? (rem_d2 - r_g) : rem_d2;
                    r_nmag  <= {r_nmag[PROD_W-2:0], ge_n};
                    r_dmag  <= {r_dmag[PROD_W-2:0], ge_d};
                    r_dcnt  <= r_dcnt - 6'd1;
                    if (r_dcnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.result_num <= r_neg ? -$signed(sat_mag) : $signed(sat_mag);
                        r_out.result_den <= r_dmag[62:0];
                        r_out.status     <= r_err;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level, front classifier, job queue and back end
// depends on rau_pkg, rau_front, rau_queue and rau_back
//
// adds, subtracts, multiplies or divides two signed fractions and returns the
// result in lowest terms, sign in the numerator, denominator positive; a zero
// result gives 0/1, and a zero input denominator or a division by a zero
// fraction gives 0/0 with status set. an item passes through these steps: the
// job is taken from the queue, two (multiply, divide) or three (add, subtract)
// products are formed in turn on the shared 32x32 multiplier, a combine step
// follows, then a binary gcd of one step per cycle, a last gcd step that forms
// the divisor, bit-serial exact division of numerator and denominator, and the
// load of the result register once the output is free. an error item goes
// straight from the queue to the result register, and a zero result skips the
// gcd and the division. the front takes request transfers into a two-entry
// queue while the back works, and the back starts the next item while a result waits
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rau_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output rau_pkg::t_res o_res
);
    import rau_pkg::*;

    logic push, full, pop, empty;
    t_job job_in, job_out;

    // classify: operand signs folded into numerators, error flags raised
    rau_front #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    // decouples request transfers from the long back-end work
    rau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    // products, gcd reduction, exact division and the result register
    rau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .o_pop   (pop),
        .i_job   (job_out),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

endmodule

>>> tb/rational_arithmetic_unit_test.sv
// rational_arithmetic_unit_test: self-checking bench for the rational arithmetic unit
// depends on rau_pkg and rational_arithmetic_unit; a queue-fed driver and a clocked monitor
module rational_arithmetic_unit_test;
    import rau_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int RAND_ITEMS = 830;
    localparam longint CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_res o_res;

    t_req pending_reqs[$];      // items waiting for the driver
    t_res expected_fracs[$];    // predicted results, oldest first
    int   mismatches = 0;
    int   results_seen = 0;
    int   items_sent = 0;
    int   error_results = 0;
    longint cycle_count = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    bit   hold_off = 1'b0;      // long receiver stall, set by the stimulus process

    rational_arithmetic_unit #(.OPERAND_WIDTH(32)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    // clock, period 8
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // magnitude of a 32-bit two's complement operand
    function automatic logic [63:0] mag_of(logic signed [31:0] v);
        return v[31] ? 64'(-64'(v)) : 64'(v);
    endfunction

    // exact fraction arithmetic in lowest terms
    function automatic t_res reduce_fraction(t_req r);
        t_res res;
        t_op op;
        logic ln_neg, rn_neg, neg;
        logic [63:0] ln, ld, rn, rd, t1, t2, nmag, dmag, g;
        op = t_op'(r.req_type);
        ln = mag_of(r.left_num);
        ld = mag_of(r.left_den);
        rn = mag_of(r.right_num);
        rd = mag_of(r.right_den);
        res = '0;
        if (ld == 0 || rd == 0 || (op == OP_DIV && rn == 0)) begin
            res.status = 1'b1;
            return res;
        end
        // denominator signs move into the numerators
        ln_neg = r.left_num[31] ^ r.left_den[31];
        rn_neg = r.right_num[31] ^ r.right_den[31] ^ (op == OP_SUB);
        case (op)
            OP_ADD, OP_SUB: begin
                t1 = ln * rd;
                t2 = rn * ld;
                if (ln_neg == rn_neg) begin
                    nmag = t1 + t2;
                    neg = ln_neg;
                end else if (t1 >= t2) begin
                    nmag = t1 - t2;
                    neg = ln_neg;
                end else begin
                    nmag = t2 - t1;
                    neg = rn_neg;
                end
                dmag = ld * rd;
            end
            OP_MUL: begin
                nmag = ln * rn;
                dmag = ld * rd;
                neg = ln_neg ^ rn_neg;
            end
            default: begin
                nmag = ln * rd;
                dmag = ld * rn;
                neg = ln_neg ^ rn_neg;
            end
        endcase
        if (nmag == 0) begin
            res.result_den = 63'd1;
            return res;
        end
        g = gcd64(nmag, dmag);
        nmag = nmag / g;
        dmag = dmag / g;
        // saturation cannot arise at 32-bit operands, kept for completeness
        if (neg) begin
            if (nmag > 64'h8000_0000_0000_0000) nmag = 64'h8000_0000_0000_0000;
            res.result_num = -nmag;
        end else begin
            if (nmag > 64'h7fff_ffff_ffff_ffff) nmag = 64'h7fff_ffff_ffff_ffff;
            res.result_num = nmag;
        end
        res.result_den = dmag[62:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, t_res got, t_res want);
        mismatches++;
        $display("mismatch %s at cycle %0d: got %0d/%0d st %0b, want %0d/%0d st %0b",
                 what, cycle_count, got.result_num, got.result_den, got.status,
                 want.result_num, want.result_den, want.status);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'(signed'($urandom_range(16)) - 8);
            3: return 32'sh8000_0000 + 32'($urandom_range(3));
            4, 5: return 32'(signed'($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.req_type = 2'($urandom_range(3));
        r.left_num = rand_operand();
        r.right_num = rand_operand();
        // zero denominators now and then, mostly nonzero
        r.left_den = ($urandom_range(30) == 0) ? 32'sd0 : rand_operand();
        r.right_den = ($urandom_range(30) == 0) ? 32'sd0 : rand_operand();
        if (r.left_den == 0 && $urandom_range(1)) r.left_den = 32'sd1;
        // shared factors exercise the reduction
        if ($urandom_range(3) == 0) begin
            r.right_num = r.left_num;
            r.right_den = r.left_den;
        end
        return r;
    endfunction

    function automatic t_req mk(t_op op, int ln, int ld, int rn, int rd);
        t_req r;
        r.req_type = op;
        r.left_num = ln;
        r.left_den = ld;
        r.right_num = rn;
        r.right_den = rd;
        return r;
    endfunction

    // driver: offers queued items with random gaps, holds the payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && o_stall) begin
            // transfer pending, payload held
        end else begin
            if (i_valid) begin
                expected_fracs.push_back(reduce_fraction(i_req));
                items_sent++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                i_valid <= 1'b1;
                send_gap <= ($urandom_range(9) == 0) ? $urandom_range(300) :
                            ($urandom_range(1) ? 0 : $urandom_range(4));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transfer against the oldest prediction and drives random receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (o_res.status) error_results++;
                if (expected_fracs.size() == 0) begin
                    report_mismatch("unexpected result", o_res, '0);
                end else begin
                    t_res want;
                    want = expected_fracs.pop_front();
                    if (o_res.result_num !== want.result_num)
                        report_mismatch("numerator", o_res, want);
                    if (o_res.result_den !== want.result_den)
                        report_mismatch("denominator", o_res, want);
                    if (o_res.status !== want.status)
                        report_mismatch("status", o_res, want);
                end
            end
            if (hold_off) begin
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(7) == 0) begin
                recv_gap <= ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(5);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_fracs.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int waited;
        // directed: extremes, every operation, error and zero cases
        pending_reqs.push_back(mk(OP_ADD, 1, 2, 1, 3));
        pending_reqs.push_back(mk(OP_SUB, 1, 2, 1, 2));
        pending_reqs.push_back(mk(OP_MUL, -3, 4, 8, -9));
        pending_reqs.push_back(mk(OP_DIV, 5, -6, -10, 3));
        pending_reqs.push_back(mk(OP_ADD, 1, 0, 1, 1));
        pending_reqs.push_back(mk(OP_SUB, 1, 1, 1, 0));
        pending_reqs.push_back(mk(OP_DIV, 7, 3, 0, 5));
        pending_reqs.push_back(mk(OP_MUL, 0, 5, 3, 7));
        pending_reqs.push_back(mk(OP_ADD, 0, 0, 0, 0));
        pending_reqs.push_back(mk(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
        pending_reqs.push_back(mk(OP_DIV, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000));
        pending_reqs.push_back(mk(OP_ADD, 32'h7fff_ffff, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h7fff_fffe));
        pending_reqs.push_back(mk(OP_SUB, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000));
        pending_reqs.push_back(mk(OP_MUL, -1, -1, -1, -1));
        pending_reqs.push_back(mk(OP_DIV, 32'h8000_0000, 1, 1, 32'h7fff_ffff));
        pending_reqs.push_back(mk(OP_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 1));
        pending_reqs.push_back(mk(OP_ADD, 32'h5555_5555, 32'haaaa_aaaa,
                                  32'h5555_5555, 32'h5555_5555));
        pending_reqs.push_back(mk(OP_DIV, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // long receiver hold-off while the sender keeps offering
        repeat (60) pending_reqs.push_back(rand_req());
        wait (items_sent >= 20);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
        repeat (RAND_ITEMS - 60) pending_reqs.push_back(rand_req());
        wait (pending_reqs.size() == 0 && !i_valid && expected_fracs.size() == 0);
        waited = 0;
        while (waited < DRAIN_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        // what the run covered
        $display("%0d items sent, %0d results checked, %0d error results, %0d mismatches",
                 items_sent, results_seen, error_results, mismatches);
        if (mismatches == 0 && expected_fracs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

>>> rational_arithmetic_unit.f
rtl/rau_pkg.sv
rtl/rau_front.sv
rtl/rau_queue.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
